// ===== rtl/vlss_pkg.sv =====
// Package of the light-strip sequencer: shared codes, defaults and types.
package vlss_pkg;

  localparam int unsigned LedCountDefault   = 32;
  localparam int unsigned SignalLedsDefault = 4;
  localparam int unsigned QueueDepthDefault = 4;

  // Item kinds.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_MODE   = 3'd1;
  localparam logic [2:0] KIND_SIGNAL = 3'd2;
  localparam logic [2:0] KIND_BRAKE  = 3'd3;
  localparam logic [2:0] KIND_TEST   = 3'd4;

  // Light modes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_BRIGHT = 2'd2;
  localparam logic [1:0] MODE_HAZARD = 2'd3;

  // Turn signal selections.
  localparam logic [1:0] SIG_NONE  = 2'd0;
  localparam logic [1:0] SIG_LEFT  = 2'd1;
  localparam logic [1:0] SIG_RIGHT = 2'd2;

  // Value that sets a flag.
  localparam logic [1:0] FLAG_ON = 2'd1;

  // LED colours.
  localparam logic [1:0] COL_BLACK  = 2'd0;
  localparam logic [1:0] COL_WHITE  = 2'd1;
  localparam logic [1:0] COL_RED    = 2'd2;
  localparam logic [1:0] COL_ORANGE = 2'd3;

  // Animation kinds.
  localparam logic [1:0] ANIM_NONE   = 2'd0;
  localparam logic [1:0] ANIM_GROW   = 2'd1;
  localparam logic [1:0] ANIM_SHRINK = 2'd2;

  // Register indexes in the order of the register map.
  localparam logic [2:0] REG_REAR   = 3'd0;
  localparam logic [2:0] REG_BLINK  = 3'd1;
  localparam logic [2:0] REG_SWEEP  = 3'd2;
  localparam logic [2:0] REG_ANIM   = 3'd3;
  localparam logic [2:0] REG_NORMAL = 3'd4;
  localparam logic [2:0] REG_BRIGHT = 3'd5;
  localparam logic [2:0] REG_BRAKE  = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] time_ms;
    logic [1:0]  value;
  } item_t;

  typedef struct packed {
    logic        rear_strip;
    logic [15:0] blink_period_ms;
    logic [15:0] sweep_step_ms;
    logic [15:0] anim_step_ms;
    logic [7:0]  normal_level;
    logic [7:0]  bright_level;
    logic [7:0]  brake_level;
  } cfg_t;

endpackage

// ===== rtl/vlss_front.sv =====
// Front end: accepts input beats, tracks the test flag and forwards work to the queue.
module vlss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [31:0]         time_ms_i,
  input  logic [1:0]          value_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output vlss_pkg::item_t     push_item_o
);

  logic test_q, test_d;
  logic fwd;
  logic accepted;

  assign in_ready_o = push_ready_i;
  assign accepted   = in_valid_i && push_ready_i;

  // Ticks are dropped while testing; the test flag itself never leaves this stage.
  always_comb begin
    fwd    = 1'b0;
    test_d = test_q;
    unique case (kind_i)
      vlss_pkg::KIND_TICK: begin
        fwd = !test_q;
      end
      vlss_pkg::KIND_MODE, vlss_pkg::KIND_SIGNAL, vlss_pkg::KIND_BRAKE: begin
        fwd = 1'b1;
      end
      vlss_pkg::KIND_TEST: begin
        if (accepted) begin
          test_d = (value_i == vlss_pkg::FLAG_ON);
        end
      end
      default: begin
        fwd = 1'b0;
      end
    endcase
  end

  assign push_valid_o        = in_valid_i && fwd;
  assign push_item_o.kind    = kind_i;
  assign push_item_o.time_ms = time_ms_i;
  assign push_item_o.value   = value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_q <= 1'b0;
    end else begin
      test_q <= test_d;
    end
  end

endmodule

// ===== rtl/vlss_queue.sv =====
// Short first-in first-out queue between the front end and the frame engine.
module vlss_queue #(
  parameter int unsigned Depth = vlss_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  vlss_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output vlss_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vlss_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");
`endif

endmodule

// ===== rtl/vlss_back.sv =====
// Frame engine: applies commands, evaluates ticks and streams one beat per LED.
module vlss_back #(
  parameter int unsigned LED_COUNT   = vlss_pkg::LedCountDefault,
  parameter int unsigned SIGNAL_LEDS = vlss_pkg::SignalLedsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vlss_pkg::cfg_t  cfg_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  vlss_pkg::item_t pop_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [5:0]      led_index_o,
  output logic [1:0]      color_o,
  output logic [7:0]      brightness_o,
  output logic            last_o
);

  localparam int unsigned Mid         = LED_COUNT / 2;
  localparam int unsigned SigW        = (SIGNAL_LEDS > 1) ? $clog2(SIGNAL_LEDS) : 1;
  localparam int unsigned ShrinkGuard = 200;
  localparam int unsigned Div10Mul    = 205;
  localparam int unsigned Div10Shift  = 11;
  localparam logic [7:0]  MidV        = 8'(Mid);
  localparam logic [7:0]  SlV         = 8'(SIGNAL_LEDS);
  localparam logic [7:0]  LcV         = 8'(LED_COUNT);
  localparam logic [SigW-1:0] KMax    = SigW'(SIGNAL_LEDS - 1);
  localparam logic [5:0]  LastIdx     = 6'(LED_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  // Exact for every 8-bit value: multiply by a scaled reciprocal of ten.
  function automatic logic [7:0] div10(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'(Div10Mul);
    return 8'(prod >> Div10Shift);
  endfunction

  state_e state_q, state_d;
  logic [5:0] idx_q, idx_d;

  // Sequencer state.
  logic [1:0]  mode_q, mode_d;
  logic        prev_on_q, prev_on_d;
  logic        left_q, left_d, right_q, right_d, brake_q, brake_d;
  logic [1:0]  anim_q, anim_d;
  logic [7:0]  sweep_q, sweep_d;
  logic        phase_q, phase_d;
  logic [31:0] last_tog_q, last_tog_d, last_sw_q, last_sw_d, last_anim_q, last_anim_d;
  logic [7:0]  level_q, level_d;

  // The frame is kept as a description of lit ranges rather than per LED.
  logic [1:0]      fcol_q, fcol_d;
  logic            main_en_q, main_en_d;
  logic            span_en_q, span_en_d;
  logic [7:0]      span_w_q, span_w_d;
  logic            left_en_q, left_en_d;
  logic [SigW-1:0] left_lo_q, left_lo_d;
  logic            right_en_q, right_en_d;
  logic [SigW-1:0] right_k_q, right_k_d;

  // Output register.
  logic       out_valid_q;
  logic [5:0] out_idx_q;
  logic [1:0] out_col_q;
  logic [7:0] out_lvl_q;
  logic       out_last_q;
  logic       out_free;

  // Tick evaluation terms.
  logic        on;
  logic [1:0]  ak0;
  logic [7:0]  sp0;
  logic [31:0] t;
  logic        anim_due, tog_due, sw_due;
  logic [7:0]  g_next;
  logic        g_end;
  logic [7:0]  s_sp, speed, s_next;
  logic [1:0]  main_col;
  logic [1:0]  led_col;

  assign t        = pop_item_i.time_ms;
  assign on       = (mode_q != vlss_pkg::MODE_OFF);
  assign main_col = cfg_i.rear_strip ? vlss_pkg::COL_RED : vlss_pkg::COL_WHITE;
  assign anim_due = ((t - last_anim_q) >= 32'(cfg_i.anim_step_ms));
  assign tog_due  = ((t - last_tog_q) > 32'(cfg_i.blink_period_ms));
  assign sw_due   = ((t - last_sw_q) > 32'(cfg_i.sweep_step_ms));

  always_comb begin
    if (!prev_on_q && on) begin
      ak0 = vlss_pkg::ANIM_GROW;
      sp0 = 8'd0;
    end else if (prev_on_q && !on) begin
      ak0 = vlss_pkg::ANIM_SHRINK;
      sp0 = MidV;
    end else begin
      ak0 = anim_q;
      sp0 = sweep_q;
    end
  end

  assign g_next = sp0 + 8'd1 + div10(sp0);
  assign g_end  = (g_next >= MidV);
  assign s_sp   = (sp0 > 8'(ShrinkGuard)) ? MidV : sp0;
  assign speed  = (s_sp > MidV) ? 8'd1 : 8'd1 + div10(MidV - s_sp);
  assign s_next = (s_sp <= speed) ? 8'd0 : s_sp - speed;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    logic            new_phase;
    logic            restart;
    logic [SigW-1:0] k;

    state_d     = state_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    prev_on_d   = prev_on_q;
    left_d      = left_q;
    right_d     = right_q;
    brake_d     = brake_q;
    anim_d      = anim_q;
    sweep_d     = sweep_q;
    phase_d     = phase_q;
    last_tog_d  = last_tog_q;
    last_sw_d   = last_sw_q;
    last_anim_d = last_anim_q;
    level_d     = level_q;
    fcol_d      = fcol_q;
    main_en_d   = main_en_q;
    span_en_d   = span_en_q;
    span_w_d    = span_w_q;
    left_en_d   = left_en_q;
    left_lo_d   = left_lo_q;
    right_en_d  = right_en_q;
    right_k_d   = right_k_q;
    new_phase   = phase_q;
    restart     = 1'b0;
    k           = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          unique case (pop_item_i.kind)
            vlss_pkg::KIND_MODE: begin
              mode_d = pop_item_i.value;
            end
            vlss_pkg::KIND_SIGNAL: begin
              unique case (pop_item_i.value)
                vlss_pkg::SIG_NONE: begin
                  left_d  = 1'b0;
                  right_d = 1'b0;
                end
                vlss_pkg::SIG_LEFT: begin
                  left_d  = 1'b1;
                  right_d = 1'b0;
                end
                vlss_pkg::SIG_RIGHT: begin
                  left_d  = 1'b0;
                  right_d = 1'b1;
                end
                default: begin
                  left_d = left_q;
                end
              endcase
            end
            vlss_pkg::KIND_BRAKE: begin
              brake_d = (pop_item_i.value == vlss_pkg::FLAG_ON);
            end
            vlss_pkg::KIND_TICK: begin
              state_d   = ST_EMIT;
              idx_d     = '0;
              prev_on_d = on;
              if (ak0 != vlss_pkg::ANIM_NONE) begin
                anim_d  = ak0;
                sweep_d = sp0;
                // A step that is not yet due leaves the stored frame as it was.
                if (anim_due) begin
                  last_anim_d = t;
                  fcol_d      = main_col;
                  main_en_d   = 1'b0;
                  span_en_d   = 1'b0;
                  left_en_d   = 1'b0;
                  right_en_d  = 1'b0;
                  if (ak0 == vlss_pkg::ANIM_GROW) begin
                    span_en_d = 1'b1;
                    span_w_d  = sp0;
                    if (g_end) begin
                      anim_d    = vlss_pkg::ANIM_NONE;
                      sweep_d   = 8'd0;
                      main_en_d = on;
                    end else begin
                      sweep_d = g_next;
                    end
                  end else if (ak0 == vlss_pkg::ANIM_SHRINK) begin
                    span_en_d = (s_next != 8'd0);
                    span_w_d  = s_sp;
                    sweep_d   = s_next;
                    if (s_next == 8'd0) begin
                      anim_d = vlss_pkg::ANIM_NONE;
                    end
                  end
                end
              end else begin
                fcol_d     = main_col;
                main_en_d  = on;
                span_en_d  = 1'b0;
                left_en_d  = 1'b0;
                right_en_d = 1'b0;
                if (on) begin
                  level_d = (mode_q == vlss_pkg::MODE_BRIGHT) ?
                            cfg_i.bright_level : cfg_i.normal_level;
                  if (cfg_i.rear_strip && brake_q) begin
                    level_d = cfg_i.brake_level;
                  end
                  if (mode_q == vlss_pkg::MODE_HAZARD) begin
                    if (tog_due) begin
                      new_phase  = !phase_q;
                      last_tog_d = t;
                    end
                    phase_d = new_phase;
                    if (new_phase) begin
                      left_en_d  = 1'b1;
                      left_lo_d  = '0;
                      right_en_d = 1'b1;
                      right_k_d  = KMax;
                    end
                  end else if (left_q || right_q) begin
                    if (tog_due) begin
                      new_phase  = !phase_q;
                      last_tog_d = t;
                    end
                    phase_d = new_phase;
                    restart = tog_due && new_phase;
                    if (restart) begin
                      sweep_d   = 8'd0;
                      last_sw_d = t;
                    end else if (new_phase && sw_due && (sweep_q < SlV)) begin
                      sweep_d   = sweep_q + 8'd1;
                      last_sw_d = t;
                    end
                    if (new_phase) begin
                      k          = (sweep_d >= 8'(KMax)) ? KMax : SigW'(sweep_d);
                      left_en_d  = left_q;
                      left_lo_d  = KMax - k;
                      right_en_d = right_q;
                      right_k_d  = k;
                    end
                  end
                end
              end
            end
            default: begin
              mode_d = mode_q;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == LastIdx) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Colour of the LED at the emit counter; orange is painted over the main colour.
  always_comb begin
    logic [7:0] ii;
    logic [8:0] iw;
    logic       in_left, in_right, in_main, in_span;
    ii       = {2'b00, idx_q};
    iw       = {3'b000, idx_q};
    in_left  = left_en_q && (ii >= 8'(left_lo_q)) && (ii < SlV);
    in_right = right_en_q && ((ii + SlV) >= LcV) && ((ii + SlV) <= (LcV + 8'(right_k_q)));
    in_main  = main_en_q && (ii >= SlV) && ((ii + SlV) < LcV);
    in_span  = span_en_q && ((iw + {1'b0, span_w_q}) >= 9'(Mid)) &&
               (iw <= (9'(Mid) + {1'b0, span_w_q}));
    if (in_left || in_right) begin
      led_col = vlss_pkg::COL_ORANGE;
    end else if (in_main || in_span) begin
      led_col = fcol_q;
    end else begin
      led_col = vlss_pkg::COL_BLACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      mode_q      <= vlss_pkg::MODE_OFF;
      prev_on_q   <= 1'b0;
      left_q      <= 1'b0;
      right_q     <= 1'b0;
      brake_q     <= 1'b0;
      anim_q      <= vlss_pkg::ANIM_NONE;
      sweep_q     <= '0;
      phase_q     <= 1'b1;
      last_tog_q  <= '0;
      last_sw_q   <= '0;
      last_anim_q <= '0;
      level_q     <= '0;
      fcol_q      <= vlss_pkg::COL_BLACK;
      main_en_q   <= 1'b0;
      span_en_q   <= 1'b0;
      span_w_q    <= '0;
      left_en_q   <= 1'b0;
      left_lo_q   <= '0;
      right_en_q  <= 1'b0;
      right_k_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mode_q      <= mode_d;
      prev_on_q   <= prev_on_d;
      left_q      <= left_d;
      right_q     <= right_d;
      brake_q     <= brake_d;
      anim_q      <= anim_d;
      sweep_q     <= sweep_d;
      phase_q     <= phase_d;
      last_tog_q  <= last_tog_d;
      last_sw_q   <= last_sw_d;
      last_anim_q <= last_anim_d;
      level_q     <= level_d;
      fcol_q      <= fcol_d;
      main_en_q   <= main_en_d;
      span_en_q   <= span_en_d;
      span_w_q    <= span_w_d;
      left_en_q   <= left_en_d;
      left_lo_q   <= left_lo_d;
      right_en_q  <= right_en_d;
      right_k_q   <= right_k_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_idx_q  <= idx_q;
      out_col_q  <= led_col;
      out_lvl_q  <= level_q;
      out_last_q <= (idx_q == LastIdx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign led_index_o  = out_idx_q;
  assign color_o      = out_col_q;
  assign brightness_o = out_lvl_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && idx_q == LastIdx) |=> (state_q == ST_IDLE))
    else $error("frame engine did not return to idle after the last beat");
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && pop_valid_i && pop_item_i.kind == vlss_pkg::KIND_TICK)
    |=> (state_q == ST_EMIT && idx_q == '0))
    else $error("tick did not start a frame at the first LED");
  a_grow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (anim_q == vlss_pkg::ANIM_GROW) |-> (sweep_q < MidV))
    else $error("startup sweep position past the centre");
  a_shrink_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (anim_q == vlss_pkg::ANIM_SHRINK) |-> (sweep_q != 8'd0 && sweep_q <= MidV))
    else $error("shutdown sweep position out of range");
`endif

endmodule

// ===== rtl/vehicle_led_strip_light_sequencer.sv =====
// Top level of the vehicle light-strip sequencer with its register block.
//
// The input channel takes one beat per item: commands (mode, turn signal,
// brake, test) and ticks that carry the time in milliseconds. Commands give
// no output. Each tick taken while test mode is off gives a frame of
// LED_COUNT output beats, LED 0 first, with last set on the final LED.
// Unknown kinds and ticks in test mode are taken and dropped by the front end.
// A queue of QUEUE_DEPTH items sits between the front end and the frame
// engine, so the input keeps taking items while a frame is streaming.
// The frame engine applies each command while idle. A tick is evaluated in the
// idle state; the engine then streams one LED a cycle from its emit counter
// while the output register is free, taking no new item until the frame ends.
// A popped tick sets the emit state; beats are offered from the output register.
// When the receiver stalls, the output register holds its beat and the engine
// waits; once the queue is full the input is held off.
// Registers sit on an APB-style port with pready always high, one per word, each
// reset to its default. Reset also sets the control state (not queue storage or
// output data), leaving a black frame at brightness zero; no clearing pass is needed.
module vehicle_led_strip_light_sequencer #(
  parameter int unsigned LED_COUNT   = vlss_pkg::LedCountDefault,
  parameter int unsigned SIGNAL_LEDS = vlss_pkg::SignalLedsDefault,
  parameter int unsigned QUEUE_DEPTH = vlss_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] time_ms_i,
  input  logic [1:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  led_index_o,
  output logic [1:0]  color_o,
  output logic [7:0]  brightness_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam vlss_pkg::cfg_t CfgReset = '{
    rear_strip:      1'b0,
    blink_period_ms: 16'd500,
    sweep_step_ms:   16'd50,
    anim_step_ms:    16'd20,
    normal_level:    8'd128,
    bright_level:    8'd255,
    brake_level:     8'd255
  };

  vlss_pkg::cfg_t  cfg_q;
  logic [2:0]      reg_idx;
  logic            cfg_we;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  vlss_pkg::item_t push_item, pop_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        vlss_pkg::REG_REAR:   cfg_q.rear_strip      <= pwdata[0];
        vlss_pkg::REG_BLINK:  cfg_q.blink_period_ms <= pwdata[15:0];
        vlss_pkg::REG_SWEEP:  cfg_q.sweep_step_ms   <= pwdata[15:0];
        vlss_pkg::REG_ANIM:   cfg_q.anim_step_ms    <= pwdata[15:0];
        vlss_pkg::REG_NORMAL: cfg_q.normal_level    <= pwdata[7:0];
        vlss_pkg::REG_BRIGHT: cfg_q.bright_level    <= pwdata[7:0];
        vlss_pkg::REG_BRAKE:  cfg_q.brake_level     <= pwdata[7:0];
        default:              cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vlss_pkg::REG_REAR:   prdata = {31'd0, cfg_q.rear_strip};
      vlss_pkg::REG_BLINK:  prdata = {16'd0, cfg_q.blink_period_ms};
      vlss_pkg::REG_SWEEP:  prdata = {16'd0, cfg_q.sweep_step_ms};
      vlss_pkg::REG_ANIM:   prdata = {16'd0, cfg_q.anim_step_ms};
      vlss_pkg::REG_NORMAL: prdata = {24'd0, cfg_q.normal_level};
      vlss_pkg::REG_BRIGHT: prdata = {24'd0, cfg_q.bright_level};
      vlss_pkg::REG_BRAKE:  prdata = {24'd0, cfg_q.brake_level};
      default:              prdata = 32'd0;
    endcase
  end

  vlss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .time_ms_i    (time_ms_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  vlss_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  vlss_back #(
    .LED_COUNT   (LED_COUNT),
    .SIGNAL_LEDS (SIGNAL_LEDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .color_o      (color_o),
    .brightness_o (brightness_o),
    .last_o       (last_o)
  );

endmodule
